// File: hdl/mea_pkg.sv
package mea_pkg;

    localparam int unsigned XLEN = 32;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_AND = 6'd2, OP_BREAK = 6'd3, OP_DIV = 6'd4,
        OP_DIVU = 6'd5, OP_JALR = 6'd6, OP_JR = 6'd7, OP_MFHI = 6'd8, OP_MFLO = 6'd9,
        OP_MTHI = 6'd10, OP_MTLO = 6'd11, OP_MULT = 6'd12, OP_MULTU = 6'd13,
        OP_NOR = 6'd14, OP_OR = 6'd15, OP_SLL = 6'd16, OP_SLLV = 6'd17, OP_SLT = 6'd18,
        OP_SLTU = 6'd19, OP_SRA = 6'd20, OP_SRAV = 6'd21, OP_SRL = 6'd22,
        OP_SRLV = 6'd23, OP_SUB = 6'd24, OP_SUBU = 6'd25, OP_SYSCALL = 6'd26,
        OP_XOR = 6'd27, OP_ADDI = 6'd28, OP_ADDIU = 6'd29, OP_ANDI = 6'd30,
        OP_BEQ = 6'd31, OP_BGEZ = 6'd32, OP_BGTZ = 6'd33, OP_BLEZ = 6'd34,
        OP_BLTZ = 6'd35, OP_BNE = 6'd36, OP_LB = 6'd37, OP_LBU = 6'd38, OP_LH = 6'd39,
        OP_LHU = 6'd40, OP_LUI = 6'd41, OP_LW = 6'd42, OP_LWC1 = 6'd43, OP_ORI = 6'd44,
        OP_SB = 6'd45, OP_SLTI = 6'd46, OP_SLTIU = 6'd47, OP_SH = 6'd48, OP_SW = 6'd49,
        OP_SWC1 = 6'd50, OP_XORI = 6'd51, OP_J = 6'd52, OP_JAL = 6'd53
    } t_op;

    typedef enum logic [2:0] {
        EXC_NONE = 3'd0, EXC_OVF = 3'd1, EXC_BRK = 3'd2, EXC_SYS = 3'd3, EXC_DIVZ = 3'd4
    } t_exc;

    // back-end unit selection
    typedef enum logic [1:0] {
        U_SIMPLE = 2'd0, U_MUL = 2'd1, U_DIV = 2'd2
    } t_unit;

    typedef struct packed {
        t_unit             unit;
        logic              sgn;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [XLEN-1:0]   front;
        logic [XLEN-1:0]   back;
        logic [XLEN-1:0]   next;
        t_exc              exc;
    } t_item;

    // divider: one quotient bit per stage, XLEN stages
    localparam int unsigned DIV_STAGES = XLEN;
    // back-end pipeline depth in registers, the same for every unit
    localparam int unsigned BE_LAT = DIV_STAGES + 2;

endpackage

// File: hdl/mea_front.sv
module mea_front (
    input  logic                i_clk,
    input  logic [5:0]          i_action,
    input  logic [31:0]         i_rs_value,
    input  logic [31:0]         i_rt_value,
    input  logic [31:0]         i_immediate,
    input  logic [4:0]          i_shift_amount,
    input  logic [31:0]         i_pc,
    input  logic [31:0]         i_jump_target,
    input  logic                i_take,
    output mea_pkg::t_item      o_item
);
    import mea_pkg::*;

    t_item n_item;
    t_item r_item;
    logic [31:0] sum, dif, sumi, next, target, sra_v, srav_v;
    logic        lt_s, lt_u, lti_s, lti_u;

    always_comb begin
        next   = i_pc + 32'd4;
        target = i_pc + i_immediate;
        sum    = i_rs_value + i_rt_value;
        dif    = i_rs_value - i_rt_value;
        sumi   = i_rs_value + i_immediate;
        lt_s   = $signed(i_rs_value) < $signed(i_rt_value);
        lt_u   = i_rs_value < i_rt_value;
        lti_s  = $signed(i_rs_value) < $signed(i_immediate);
        lti_u  = i_rs_value < i_immediate;
        sra_v  = 32'($signed(i_rt_value) >>> i_shift_amount);
        srav_v = 32'($signed(i_rt_value) >>> i_rs_value[4:0]);
        n_item       = '0;
        n_item.unit  = U_SIMPLE;
        n_item.a     = i_rs_value;
        n_item.b     = i_rt_value;
        n_item.next  = next;
        n_item.exc   = EXC_NONE;
        case (t_op'(i_action))
            OP_ADD: begin
                n_item.front = sum;
                if (~(i_rs_value[31] ^ i_rt_value[31]) & (i_rs_value[31] ^ sum[31]))
                    n_item.exc = EXC_OVF;
            end
            OP_SUB: begin
                n_item.front = dif;
                if ((i_rs_value[31] ^ i_rt_value[31]) & (i_rs_value[31] ^ dif[31]))
                    n_item.exc = EXC_OVF;
            end
            OP_ADDI: begin
                n_item.front = sumi;
                if (~(i_rs_value[31] ^ i_immediate[31]) & (i_rs_value[31] ^ sumi[31]))
                    n_item.exc = EXC_OVF;
            end
            OP_ADDU:  n_item.front = sum;
            OP_SUBU:  n_item.front = dif;
            OP_AND:   n_item.front = i_rs_value & i_rt_value;
            OP_OR:    n_item.front = i_rs_value | i_rt_value;
            OP_XOR:   n_item.front = i_rs_value ^ i_rt_value;
            OP_NOR:   n_item.front = ~(i_rs_value | i_rt_value);
            OP_BREAK: n_item.exc = EXC_BRK;
            OP_SYSCALL: n_item.exc = EXC_SYS;
            OP_DIV: begin
                n_item.unit = U_DIV;
                n_item.sgn  = 1'b1;
            end
            OP_DIVU:  n_item.unit = U_DIV;
            OP_MULT: begin
                n_item.unit = U_MUL;
                n_item.sgn  = 1'b1;
            end
            OP_MULTU: n_item.unit = U_MUL;
            OP_JALR, OP_JR: n_item.next = i_rs_value;
            OP_SLL:   n_item.front = i_rt_value << i_shift_amount;
            OP_SLLV:  n_item.front = i_rt_value << i_rs_value[4:0];
            OP_SRL:   n_item.front = i_rt_value >> i_shift_amount;
            OP_SRLV:  n_item.front = i_rt_value >> i_rs_value[4:0];
            OP_SRA:   n_item.front = sra_v;
            OP_SRAV:  n_item.front = srav_v;
            OP_SLT:   n_item.front = {31'd0, lt_s};
            OP_SLTU:  n_item.front = {31'd0, lt_u};
            OP_SLTI:  n_item.front = {31'd0, lti_s};
            OP_SLTIU: n_item.front = {31'd0, lti_u};
            OP_ADDIU, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWC1:
                n_item.front = sumi;
            OP_SB, OP_SH, OP_SW, OP_SWC1: begin
                n_item.front = sumi;
                n_item.back  = i_rt_value;
            end
            OP_ANDI:  n_item.front = i_rs_value & i_immediate;
            OP_ORI:   n_item.front = i_rs_value | i_immediate;
            OP_XORI:  n_item.front = i_rs_value ^ i_immediate;
            OP_LUI:   n_item.front = i_immediate << 16;
            OP_BEQ:   n_item.front = (i_rs_value == i_rt_value) ? target : next;
            OP_BNE:   n_item.front = (i_rs_value != i_rt_value) ? target : next;
            OP_BGEZ:  n_item.front = !i_rs_value[31] ? target : next;
            OP_BLTZ:  n_item.front = i_rs_value[31] ? target : next;
            OP_BGTZ:  n_item.front = (!i_rs_value[31] && i_rs_value != 0) ? target : next;
            OP_BLEZ:  n_item.front = (i_rs_value[31] || i_rs_value == 0) ? target : next;
            OP_J, OP_JAL: n_item.front = i_jump_target;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: hdl/mea_back.sv
module mea_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mea_pkg::t_item      i_item,
    output logic                o_valid,
    output logic [31:0]         o_front,
    output logic [31:0]         o_back,
    output logic [31:0]         o_next,
    output logic [2:0]          o_exc
);
    import mea_pkg::*;

    localparam int unsigned NS = BE_LAT;

    // stage 0: operand preparation
    logic            r_v   [NS];
    t_item           r_it  [NS];
    logic [31:0]     r_rem [DIV_STAGES+1];
    logic [31:0]     r_quo [DIV_STAGES+1];
    logic [31:0]     r_div [DIV_STAGES+1];
    logic            r_qneg[DIV_STAGES+1];
    logic            r_rneg[DIV_STAGES+1];

    logic [31:0] ma, mb;
    logic        na, nb;
    logic [32:0] n_rem [DIV_STAGES];
    logic [32:0] trial [DIV_STAGES];
    logic signed [32:0] ea, eb;
    logic signed [65:0] prod_w;
    logic [63:0] n_prod;
    t_item       it0;
    t_item       last;
    logic [31:0] qf, rf;

    always_comb begin
        na = i_item.sgn & i_item.a[31];
        nb = i_item.sgn & i_item.b[31];
        ma = na ? 32'd0 - i_item.a : i_item.a;
        mb = nb ? 32'd0 - i_item.b : i_item.b;
        // 33x33 signed multiply covers both signed and unsigned operands
        ea = {i_item.sgn & i_item.a[31], i_item.a};
        eb = {i_item.sgn & i_item.b[31], i_item.b};
        prod_w = ea * eb;
        n_prod = prod_w[63:0];
        it0 = i_item;
        if (i_item.unit == U_MUL) begin
            it0.front = n_prod[63:32];
            it0.back  = n_prod[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_it[0]   <= it0;
        r_rem[0]  <= 32'd0;
        r_quo[0]  <= ma;
        r_div[0]  <= mb;
        r_qneg[0] <= na ^ nb;
        r_rneg[0] <= na;
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        always_comb begin
            trial[s] = {r_rem[s], r_quo[s][31]} - {1'b0, r_div[s]};
            n_rem[s] = trial[s][32] ? {r_rem[s], r_quo[s][31]} : trial[s];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_it[s+1]   <= r_it[s];
            r_rem[s+1]  <= n_rem[s][31:0];
            r_quo[s+1]  <= {r_quo[s][30:0], ~trial[s][32]};
            r_div[s+1]  <= r_div[s];
            r_qneg[s+1] <= r_qneg[s];
            r_rneg[s+1] <= r_rneg[s];
        end
    end

    always_comb begin
        last = r_it[DIV_STAGES];
        qf = r_qneg[DIV_STAGES] ? 32'd0 - r_quo[DIV_STAGES] : r_quo[DIV_STAGES];
        rf = r_rneg[DIV_STAGES] ? 32'd0 - r_rem[DIV_STAGES] : r_rem[DIV_STAGES];
        if (last.unit == U_DIV) begin
            if (r_div[DIV_STAGES] == 32'd0) begin
                last.front = '0;
                last.back  = '0;
                last.exc   = EXC_DIVZ;
            end else begin
                last.front = qf;
                last.back  = rf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[NS-1] <= 1'b0;
        end else begin
            r_v[NS-1] <= r_v[DIV_STAGES];
        end
        r_it[NS-1] <= last;
    end

    assign o_valid = r_v[NS-1];
    assign o_front = r_it[NS-1].front;
    assign o_back  = r_it[NS-1].back;
    assign o_next  = r_it[NS-1].next;
    assign o_exc   = r_it[NS-1].exc;

`ifndef SYNTHESIS
    a_divz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_exc == EXC_DIVZ |-> o_front == 32'd0 && o_back == 32'd0)
        else $error("divide by zero result not cleared");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##(NS-1) o_valid)
        else $error("back-end latency mismatch");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[DIV_STAGES] |=> !o_valid)
        else $error("spurious result");
`endif

endmodule

// File: hdl/mips_execute_stage_alu.sv
// Channel  | Ports                                      | Handshake
// input    | i_action .. i_jump_target                  | i_start && !o_busy
// result   | o_result_front, o_result_back, o_next_addr, o_exception | o_done strobe
// Every instruction enters the front register on the accepting edge; one per cycle is taken.
// o_done rises once the item has passed the front register, the operand and
// multiply stage, the 32-stage restoring divider pipeline and the output register.
// o_busy is held low: the back end never stalls and the receiver cannot stall.
// Reset is synchronous, active low, and clears only the valid bits.
module mips_execute_stage_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [5:0]  i_action,
    input  logic [31:0] i_rs_value,
    input  logic [31:0] i_rt_value,
    input  logic [31:0] i_immediate,
    input  logic [4:0]  i_shift_amount,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_jump_target,
    output logic        o_done,
    output logic [31:0] o_result_front,
    output logic [31:0] o_result_back,
    output logic [31:0] o_next_addr,
    output logic [2:0]  o_exception
);
    import mea_pkg::*;

    t_item item;
    logic  r_fv;
    logic  take;

    assign o_busy = 1'b0;
    assign take   = i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= take;
        end
    end

    mea_front u_front (
        .i_clk, .i_action, .i_rs_value, .i_rt_value, .i_immediate,
        .i_shift_amount, .i_pc, .i_jump_target, .i_take(take), .o_item(item)
    );

    mea_back u_back (
        .i_clk, .i_rst_n, .i_valid(r_fv), .i_item(item), .o_valid(o_done),
        .o_front(o_result_front), .o_back(o_result_back), .o_next(o_next_addr),
        .o_exc(o_exception)
    );

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_fv)
        else $error("accepted transaction lost");
    a_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_exception <= 3'd4)
        else $error("bad exception code");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mea_pkg::*;

    typedef struct {
        logic [31:0] front;
        logic [31:0] back;
        logic [31:0] next;
        logic [2:0]  exc;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [5:0]  i_action;
    logic [31:0] i_rs_value;
    logic [31:0] i_rt_value;
    logic [31:0] i_immediate;
    logic [4:0]  i_shift_amount;
    logic [31:0] i_pc;
    logic [31:0] i_jump_target;
    logic        o_done;
    logic [31:0] o_result_front;
    logic [31:0] o_result_back;
    logic [31:0] o_next_addr;
    logic [2:0]  o_exception;

    t_expect exec_results_q[$];
    int      n_errors;
    int      n_sent;
    int      n_checked;

    mips_execute_stage_alu u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end

    function automatic logic [31:0] shift_right_arith(logic [31:0] v, logic [4:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    function automatic t_expect execute_instr(logic [5:0] op, logic [31:0] rs, logic [31:0] rt,
                                              logic [31:0] im, logic [4:0] sa,
                                              logic [31:0] pc, logic [31:0] jt);
        t_expect     e;
        logic [31:0] target;
        logic [31:0] b;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        e.front = '0;
        e.back = '0;
        e.next = pc + 32'd4;
        e.exc = EXC_NONE;
        target = pc + im;
        case (op)
            OP_ADD, OP_ADDI: begin
                b = (op == OP_ADDI) ? im : rt;
                e.front = rs + b;
                if (~(rs[31] ^ b[31]) & (rs[31] ^ e.front[31])) e.exc = EXC_OVF;
            end
            OP_SUB: begin
                e.front = rs - rt;
                if ((rs[31] ^ rt[31]) & (rs[31] ^ e.front[31])) e.exc = EXC_OVF;
            end
            OP_ADDU: e.front = rs + rt;
            OP_AND: e.front = rs & rt;
            OP_BREAK: e.exc = EXC_BRK;
            OP_DIV: begin
                if (rt == 0) begin
                    e.exc = EXC_DIVZ;
                end else begin
                    ma = rs[31] ? -rs : rs;
                    mb = rt[31] ? -rt : rt;
                    q = ma / mb;
                    r = ma % mb;
                    e.front = (rs[31] != rt[31]) ? -q : q;
                    e.back = rs[31] ? -r : r;
                end
            end
            OP_DIVU: begin
                if (rt == 0) begin
                    e.exc = EXC_DIVZ;
                end else begin
                    e.front = rs / rt;
                    e.back = rs % rt;
                end
            end
            OP_JALR, OP_JR: e.next = rs;
            OP_MULT: begin
                prod = $unsigned($signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt}));
                {e.front, e.back} = prod;
            end
            OP_MULTU: begin
                prod = {32'd0, rs} * {32'd0, rt};
                {e.front, e.back} = prod;
            end
            OP_NOR: e.front = ~(rs | rt);
            OP_OR: e.front = rs | rt;
            OP_SLL: e.front = rt << sa;
            OP_SLLV: e.front = rt << rs[4:0];
            OP_SLT: e.front = ($signed(rs) < $signed(rt)) ? 32'd1 : 32'd0;
            OP_SLTU: e.front = (rs < rt) ? 32'd1 : 32'd0;
            OP_SRA: e.front = shift_right_arith(rt, sa);
            OP_SRAV: e.front = shift_right_arith(rt, rs[4:0]);
            OP_SRL: e.front = rt >> sa;
            OP_SRLV: e.front = rt >> rs[4:0];
            OP_SUBU: e.front = rs - rt;
            OP_SYSCALL: e.exc = EXC_SYS;
            OP_XOR: e.front = rs ^ rt;
            OP_ADDIU: e.front = rs + im;
            OP_ANDI: e.front = rs & im;
            OP_BEQ: e.front = (rs == rt) ? target : e.next;
            OP_BGEZ: e.front = !rs[31] ? target : e.next;
            OP_BGTZ: e.front = (!rs[31] && rs != 0) ? target : e.next;
            OP_BLEZ: e.front = (rs[31] || rs == 0) ? target : e.next;
            OP_BLTZ: e.front = rs[31] ? target : e.next;
            OP_BNE: e.front = (rs != rt) ? target : e.next;
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWC1: e.front = rs + im;
            OP_LUI: e.front = im << 16;
            OP_ORI: e.front = rs | im;
            OP_SB, OP_SH, OP_SW, OP_SWC1: begin
                e.front = rs + im;
                e.back = rt;
            end
            OP_SLTI: e.front = ($signed(rs) < $signed(im)) ? 32'd1 : 32'd0;
            OP_SLTIU: e.front = (rs < im) ? 32'd1 : 32'd0;
            OP_XORI: e.front = rs ^ im;
            OP_J, OP_JAL: e.front = jt;
            default: ;
        endcase
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("ERROR %0t: %s got %08h expected %08h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_done) begin
            if (exec_results_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_result_front, 32'd0);
            end else begin
                e = exec_results_q.pop_front();
                n_checked++;
                if (o_result_front !== e.front) report_mismatch("front", o_result_front, e.front);
                if (o_result_back !== e.back) report_mismatch("back", o_result_back, e.back);
                if (o_next_addr !== e.next) report_mismatch("next_addr", o_next_addr, e.next);
                if (o_exception !== e.exc) report_mismatch("exception", o_exception, e.exc);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom();
        endcase
    endfunction

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) != 0) return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // start stays high across back-to-back transactions; lowered only by the gap or drain
    task automatic send_instr(logic [5:0] op, logic [31:0] rs, logic [31:0] rt,
                              logic [31:0] im, logic [4:0] sa, logic [31:0] pc,
                              logic [31:0] jt);
        i_start <= 1'b1;
        i_action <= op;
        i_rs_value <= rs;
        i_rt_value <= rt;
        i_immediate <= im;
        i_shift_amount <= sa;
        i_pc <= pc;
        i_jump_target <= jt;
        do @(posedge i_clk); while (o_busy);
        exec_results_q.push_back(execute_instr(op, rs, rt, im, sa, pc, jt));
        n_sent++;
        idle_gap();
    endtask

    task automatic send_op(logic [5:0] op, logic [31:0] rs, logic [31:0] rt);
        send_instr(op, rs, rt, rand_word(), 5'($urandom()), $urandom(), $urandom());
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_start <= 1'b0;
        while (exec_results_q.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (BE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_ADD, 32'h7FFF_FFFF, 32'd1);
        send_op(OP_SUB, 32'h8000_0000, 32'd1);
        send_instr(OP_ADDI, 32'h8000_0000, 0, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFC, 0);
        send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_DIV, 32'h1234, 32'd0);
        send_op(OP_DIVU, 32'hFFFF_FFFF, 32'd0);
        send_op(OP_DIV, 32'hFFFF_FFF9, 32'd2);
        send_op(OP_MULT, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr(OP_SRAV, 32'hFFFF_FFE1, 32'h8000_0000, 0, 5'd31, 0, 0);
        send_instr(OP_SRA, 0, 32'h8000_0000, 0, 5'd31, 0, 0);
        send_instr(OP_SLLV, 32'h0000_0120, 32'h1, 0, 5'd0, 0, 0);
        send_instr(OP_BGTZ, 32'd0, 0, 32'h10, 5'd0, 32'h100, 0);
        send_instr(OP_BLEZ, 32'd0, 0, 32'h10, 5'd0, 32'h100, 0);
        send_instr(OP_BEQ, 32'd5, 32'd5, 32'hFFFF_FFF0, 5'd0, 32'h40, 0);
        send_instr(OP_JR, 32'hDEAD_BEE0, 0, 0, 5'd0, 32'hFFFF_FFFC, 0);
        send_instr(OP_JAL, 0, 0, 0, 5'd0, 0, 32'hFFFF_FFFF);
        send_op(OP_BREAK, 0, 0);
        send_op(OP_SYSCALL, 0, 0);
        send_op(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr(OP_SW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_SLT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_SLTU, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();
    endtask

    task automatic test_every_op();
        for (int op = 0; op < 64; op++) send_op(6'(op), rand_word(), rand_word());
        drain();
    endtask

    task automatic test_random(int n);
        logic [5:0] op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(54, 63))
                                              : 6'($urandom_range(0, 53));
            send_instr(op, rand_word(), rand_word(), rand_word(), 5'($urandom()),
                       $urandom(), $urandom());
        end
        drain();
    endtask

    initial begin
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_action = '0;
        i_rs_value = '0;
        i_rt_value = '0;
        i_immediate = '0;
        i_shift_amount = '0;
        i_pc = '0;
        i_jump_target = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_every_op();
        test_random(600);
        test_random(600);
        if (exec_results_q.size() != 0) begin
            n_errors++;
            $display("ERROR: %0d transactions never completed", exec_results_q.size());
        end
        $display("Sent %0d instructions across all 64 opcodes incl. overflow, divide corners,",
                 n_sent);
        $display("branches and jumps; %0d results checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: mips_execute_stage_alu.f
hdl/mea_pkg.sv
hdl/mea_front.sv
hdl/mea_back.sv
hdl/mips_execute_stage_alu.sv
bench/testbench.sv
